// File: sv/baec_pkg.sv
// Shared constants, types and a helper function for the band average engrave column unit.
`timescale 1ns / 1ps

package baec_pkg;

    // Default largest band height that the accumulators are sized for.
    localparam int MAX_BAND_DEFAULT = 16;

    // Configuration register widths and reset values.
    localparam int CFG_BAND_W = 5;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_BAND_W-1:0] BAND_HEIGHT_RESET = 5'd10;
    localparam logic LIMIT_WIDTH_RESET = 1'b0;
    localparam logic COLOR_MODE_RESET = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_HEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE = 2'd2;

    // Channel width and luminance weights in Q16; the weights sum to one.
    localparam int PIX_W = 8;
    localparam int FRAC_W = 16;
    localparam int LUM_W = PIX_W + FRAC_W;
    localparam logic [FRAC_W-1:0] W_RED = 16'd13933;
    localparam logic [FRAC_W-1:0] W_GREEN = 16'd46871;
    localparam logic [FRAC_W-1:0] W_BLUE = 16'd4732;

    // Full scale of the intensity divide (the Q16 part is dropped by a shift).
    localparam int INK_STEP = 254;

    // Width of a channel sum over a band of max_band pixels.
    function automatic int sum_width(input int max_band);
        return $clog2(max_band * 255 + 1);
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;     // take the offered pixel (accumulate, or close the segment)
        logic div_step;   // one restoring division step on all three channels
        logic lum_en;     // register the luminance of the averages
        logic scale_en;   // register luminance times band height, rewind the row counter
        logic row_adv;    // a row result has been taken, move to the next row
    } baec_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;      // the offered pixel ends the segment
        logic last_row;   // the current row is the final row of the segment
    } baec_status_t;

endpackage

// File: sv/band_average_engrave_column_unit.sv
// Top level of the band average engrave column unit: configuration registers, controller, datapath.
// Throughput: while idle, pixels that do not end their segment are taken one per cycle; the
// closing pixel starts a serial divide, one step per bit of the channel sum, then the luminance
// and scaling steps, then one row result per cycle while m_ready is high.
// Reset (aresetn, synchronous, active low) clears the sums, the count and the controller.
`timescale 1ns / 1ps

module band_average_engrave_column_unit import baec_pkg::*; #(
    parameter int MAX_BAND = MAX_BAND_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Pixel request channel.
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PIX_W-1:0]       s_red,
    input  logic [PIX_W-1:0]       s_green,
    input  logic [PIX_W-1:0]       s_blue,
    input  logic                   s_segment_last,

    // Row result channel.
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_ink_white,
    output logic                   m_last_of_run,

    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_BAND_W-1:0]  cfg_data
);

    logic [CFG_BAND_W-1:0] band_height_reg;
    logic                  limit_width_reg;
    logic                  color_mode_reg;
    baec_cmd_t             cmd;
    baec_status_t          status;

    // Configuration writes are always taken. An unknown index leaves every
    // register as it was. The band height keeps the written bits; the
    // datapath clamps it when it is used.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_height_reg <= BAND_HEIGHT_RESET;
            limit_width_reg <= LIMIT_WIDTH_RESET;
            color_mode_reg <= COLOR_MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BAND_HEIGHT: band_height_reg <= cfg_data;
                REG_LIMIT_WIDTH: limit_width_reg <= cfg_data[0];
                REG_COLOR_MODE:  color_mode_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The controller takes pixel requests only while idle. Each request
    // either accumulates or, when it ends the segment, hands the sums to
    // the dividers and starts the result sequence.
    baec_ctrl #(
        .MAX_BAND (MAX_BAND)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the sums, the three serial dividers, the luminance
    // and scaling registers and the row counter that forms each result.
    baec_datapath #(
        .MAX_BAND (MAX_BAND)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .red          (s_red),
        .green        (s_green),
        .blue         (s_blue),
        .segment_last (s_segment_last),
        .band_height  (band_height_reg),
        .limit_width  (limit_width_reg),
        .color_mode   (color_mode_reg),
        .ink_white    (m_ink_white),
        .last_of_run  (m_last_of_run)
    );

endmodule

// File: sv/baec_ctrl.sv
// Controller state machine that sequences accumulation, division, scaling and row output.
`timescale 1ns / 1ps

module baec_ctrl import baec_pkg::*; #(
    parameter int MAX_BAND = MAX_BAND_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  baec_status_t status,
    output baec_cmd_t    cmd
);

    localparam int SW = sum_width(MAX_BAND);
    localparam int DCW = $clog2(SW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_LUM   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;

    always_comb begin
        state_next = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && status.close) begin
                    state_next = ST_DIV;
                    div_cnt_next = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(SW - 1)) begin
                    state_next = ST_LUM;
                end
            end
            ST_LUM: begin
                cmd.lum_en = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.row_adv = 1'b1;
                    if (status.last_row) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// File: sv/baec_datapath.sv
// Datapath: channel accumulators, serial dividers, luminance, scaling and row comparison.
`timescale 1ns / 1ps

module baec_datapath import baec_pkg::*; #(
    parameter int MAX_BAND = MAX_BAND_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  baec_cmd_t             cmd,
    output baec_status_t          status,
    input  logic [PIX_W-1:0]      red,
    input  logic [PIX_W-1:0]      green,
    input  logic [PIX_W-1:0]      blue,
    input  logic                  segment_last,
    input  logic [CFG_BAND_W-1:0] band_height,
    input  logic                  limit_width,
    input  logic                  color_mode,
    output logic                  ink_white,
    output logic                  last_of_run
);

    localparam int SW = sum_width(MAX_BAND);
    localparam int CW = $clog2(MAX_BAND + 1);
    localparam int EW = (CW > CFG_BAND_W) ? CW : CFG_BAND_W;
    localparam int PW = LUM_W + CW;
    localparam int YW = PW - FRAC_W;

    logic [SW-1:0]    sum_reg [3];
    logic [SW-1:0]    sum_next [3];
    logic [PIX_W-1:0] pixel [3];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_inc;
    logic [EW-1:0]    band_wide;
    logic [CW-1:0]    band_eff;

    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    band_seg_reg;
    logic [SW-1:0]    quo_reg [3];
    logic [CW-1:0]    rem_reg [3];

    logic [LUM_W-1:0] lum_reg;
    logic [LUM_W-1:0] lum_next;
    logic [PW-1:0]    scaled;
    logic [YW-1:0]    y_reg;
    logic [YW-1:0]    thr_reg;
    logic [CW-1:0]    row_reg;

    assign pixel[0] = red;
    assign pixel[1] = green;
    assign pixel[2] = blue;

    // Effective band height, clamped into the supported range.
    always_comb begin
        band_wide = EW'(band_height);
        if (band_wide < EW'(2)) begin
            band_wide = EW'(2);
        end else if (band_wide > EW'(MAX_BAND)) begin
            band_wide = EW'(MAX_BAND);
        end
        band_eff = band_wide[CW-1:0];
    end

    assign count_inc = count_reg + 1'b1;
    assign status.close = segment_last || (count_inc >= band_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.acc_en) begin
            count_reg <= status.close ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_en && status.close) begin
            n_reg <= count_inc;
            band_seg_reg <= band_eff;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic [CW:0] shifted;

        assign sum_next[k] = sum_reg[k] + SW'(pixel[k]);
        assign shifted = {rem_reg[k], quo_reg[k][SW-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sum_reg[k] <= '0;
            end else if (cmd.acc_en) begin
                sum_reg[k] <= status.close ? '0 : sum_next[k];
            end
        end

        // Restoring division, one quotient bit per cycle, MSB first.
        always_ff @(posedge aclk) begin
            if (cmd.acc_en && status.close) begin
                quo_reg[k] <= sum_next[k];
                rem_reg[k] <= '0;
            end else if (cmd.div_step) begin
                if (shifted >= {1'b0, n_reg}) begin
                    rem_reg[k] <= CW'(shifted - {1'b0, n_reg});
                    quo_reg[k] <= {quo_reg[k][SW-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= shifted[CW-1:0];
                    quo_reg[k] <= {quo_reg[k][SW-2:0], 1'b0};
                end
            end
        end
    end

    // Averages never exceed one channel's full scale.
    always_comb begin
        if (color_mode) begin
            lum_next = LUM_W'(W_RED) * LUM_W'(quo_reg[0][PIX_W-1:0])
                     + LUM_W'(W_GREEN) * LUM_W'(quo_reg[1][PIX_W-1:0])
                     + LUM_W'(W_BLUE) * LUM_W'(quo_reg[2][PIX_W-1:0]);
        end else begin
            lum_next = {quo_reg[0][PIX_W-1:0], {FRAC_W{1'b0}}};
        end
    end

    assign scaled = PW'(lum_reg) * PW'(band_seg_reg);

    always_ff @(posedge aclk) begin
        if (cmd.lum_en) begin
            lum_reg <= lum_next;
        end
        if (cmd.scale_en) begin
            y_reg <= scaled[PW-1:FRAC_W];
        end
    end

    // Row r is white while y >= 254 * (r + 1); thr_reg tracks that bound.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            thr_reg <= YW'(INK_STEP);
        end else if (cmd.scale_en) begin
            row_reg <= '0;
            thr_reg <= YW'(INK_STEP);
        end else if (cmd.row_adv) begin
            row_reg <= row_reg + 1'b1;
            thr_reg <= thr_reg + YW'(INK_STEP);
        end
    end

    assign status.last_row = (CW'(row_reg + 1'b1) == n_reg);
    assign last_of_run = status.last_row;

    always_comb begin
        ink_white = (y_reg >= thr_reg);
        if (limit_width) begin
            if (row_reg == '0) begin
                ink_white = 1'b1;
            end else if (row_reg == CW'(band_seg_reg - 1'b1)) begin
                ink_white = 1'b0;
            end
        end
    end

endmodule

// File: sv/baec_checker.sv
// Port-level checker for the band average engrave column unit, with its bind statement.
`timescale 1ns / 1ps

module baec_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_ink_white,
    input logic m_last_of_run
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ink_white) && $stable(m_last_of_run))
        else $error("stalled result changed");

    // Pixel requests are never taken while results are being shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while output valid");

    // Taking the final row returns the unit to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_run |=> !m_valid && s_ready)
        else $error("unit not idle after final row");

    // Out of reset no result is shown.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");

endmodule

bind band_average_engrave_column_unit baec_checker u_baec_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ink_white   (m_ink_white),
    .m_last_of_run (m_last_of_run)
);

// File: tb/band_average_engrave_column_unit_tb.sv
// Self-checking testbench for the band average engrave column unit, with its own row predictor.
`timescale 1ns / 1ps

module band_average_engrave_column_unit_tb;
    import baec_pkg::*;

    localparam int CLK_PERIOD = 10;
    // Settling time after the last row result.
    localparam int DRAIN_SLACK = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_PIXELS = 32;
    localparam int IDLE_PERCENT = 16;
    // Index with no register behind it; writes to it must leave the block unchanged.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic ink_white;
        logic last_of_run;
    } row_result_t;

    typedef enum int {
        SEG_WELL_FORMED,
        SEG_OVERLONG,
        SEG_NOISE
    } segment_kind_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [PIX_W-1:0]       s_red = '0;
    logic [PIX_W-1:0]       s_green = '0;
    logic [PIX_W-1:0]       s_blue = '0;
    logic                   s_segment_last = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_ink_white;
    logic                   m_last_of_run;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_BAND_W-1:0]  cfg_data = '0;

    // Predictor copy of the configuration and the accumulator state.
    logic [CFG_BAND_W-1:0]  band_reg = BAND_HEIGHT_RESET;
    logic                   limit_reg = LIMIT_WIDTH_RESET;
    logic                   colour_reg = COLOR_MODE_RESET;
    logic [11:0]            sum_red = '0;
    logic [11:0]            sum_green = '0;
    logic [11:0]            sum_blue = '0;
    logic [4:0]             pixels_held = '0;

    // Rows that the block owes us, oldest first.
    row_result_t            rows_due[$];
    row_result_t            row_wanted;

    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     pixels_sent = 0;
    // When set, neither side inserts idle cycles.
    logic                   steady_flow = 1'b0;
    // The receiver compares these two counters to learn that a long hold-off is wanted.
    int                     hold_off_asked = 0;
    int                     hold_off_done = 0;
    int                     hold_off_left = 0;

    band_average_engrave_column_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_segment_last (s_segment_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ink_white    (m_ink_white),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watchdog: a run that hangs on a handshake ends here as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Band height as the block uses it: out-of-range register values are clamped.
    function automatic int unsigned current_band();
        int unsigned band;
        band = 32'(band_reg);
        if (band < 2) band = 2;
        if (band > MAX_BAND_DEFAULT) band = MAX_BAND_DEFAULT;
        return band;
    endfunction

    // Accumulates one accepted pixel request and, when the segment closes, queues
    // one row result per pixel of the segment.
    function automatic void engrave_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                          input logic [PIX_W-1:0] b, input logic last);
        int unsigned band;
        int unsigned rows;
        longint unsigned avg_r;
        longint unsigned avg_g;
        longint unsigned avg_b;
        longint unsigned lum;
        longint unsigned intensity;
        row_result_t row;
        band = current_band();
        sum_red += 12'(r);
        sum_green += 12'(g);
        sum_blue += 12'(b);
        pixels_held += 5'd1;
        // A pixel that is not the last only accumulates, unless the band is already full.
        if (!last && 32'(pixels_held) < band) return;
        rows = 32'(pixels_held);
        avg_r = 64'(sum_red) / 64'(rows);
        avg_g = 64'(sum_green) / 64'(rows);
        avg_b = 64'(sum_blue) / 64'(rows);
        if (colour_reg)
            lum = 64'(W_RED) * avg_r + 64'(W_GREEN) * avg_g + 64'(W_BLUE) * avg_b;
        else
            lum = avg_r << FRAC_W;
        intensity = (lum * 64'(band)) / (64'(INK_STEP) << FRAC_W);
        for (int unsigned i = 0; i < rows; i++) begin
            row.ink_white = (intensity > 64'(i));
            // The limit rule on the last band row only bites if the segment reaches it.
            if (limit_reg) begin
                if (i == 0) row.ink_white = 1'b1;
                else if (i == band - 1) row.ink_white = 1'b0;
            end
            row.last_of_run = (i == rows - 1);
            rows_due.push_back(row);
        end
        sum_red = '0;
        sum_green = '0;
        sum_blue = '0;
        pixels_held = '0;
    endfunction

    // Row result checker: every accepted row is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rows_due.size() == 0) begin
                $error("unexpected row result: ink_white=%0b last_of_run=%0b",
                       m_ink_white, m_last_of_run);
                error_count++;
            end else begin
                row_wanted = rows_due.pop_front();
                if (m_ink_white !== row_wanted.ink_white) begin
                    $error("ink_white: expected %0b, got %0b", row_wanted.ink_white, m_ink_white);
                    error_count++;
                end
                if (m_last_of_run !== row_wanted.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           row_wanted.last_of_run, m_last_of_run);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, a steady mode, and on demand a long hold-off that
    // it counts itself so that the block fills up and refuses further pixels.
    always @(posedge aclk) begin
        if (hold_off_left != 0) begin
            m_ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (hold_off_done != hold_off_asked) begin
            m_ready <= 1'b0;
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_done <= hold_off_asked;
        end else begin
            m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic logic [PIX_W-1:0] random_channel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        return PIX_W'($urandom);
    endfunction

    // Offers one pixel request after a random number of idle cycles and waits for
    // it to be taken. Valid is left high; the caller or the next request decides.
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic last);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        s_segment_last <= last;
        do @(posedge aclk); while (!s_ready);
        engrave_pixel(r, g, b, last);
        pixels_sent++;
    endtask

    // Lowers valid and waits until every owed row has arrived and the block has settled.
    task automatic drain_rows();
        s_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // Writes all three registers, and optionally the unused index, back to back.
    // The single-bit registers get random upper data bits, which must be dropped.
    task automatic configure(input logic [CFG_BAND_W-1:0] band, input logic limit,
                             input logic colour, input logic poke_spare);
        logic [CFG_INDEX_W-1:0] idx[4];
        logic [CFG_BAND_W-1:0]  val[4];
        int                     writes;
        idx = '{REG_BAND_HEIGHT, REG_LIMIT_WIDTH, REG_COLOR_MODE, REG_SPARE};
        val = '{band, {4'($urandom), limit}, {4'($urandom), colour}, 5'd3};
        writes = poke_spare ? 4 : 3;
        for (int i = 0; i < writes; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                REG_BAND_HEIGHT: begin
                    band_reg = val[i];
                end
                REG_LIMIT_WIDTH: begin
                    limit_reg = val[i][0];
                end
                REG_COLOR_MODE: begin
                    colour_reg = val[i][0];
                end
                default: begin
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_segment(input segment_kind_t kind);
        int unsigned band;
        int unsigned len;
        logic last;
        band = current_band();
        case (kind)
            SEG_WELL_FORMED: len = $urandom_range(1, band);
            SEG_OVERLONG: len = band;
            default: len = $urandom_range(1, band + 3);
        endcase
        for (int unsigned i = 0; i < len; i++) begin
            case (kind)
                SEG_WELL_FORMED: last = (i == len - 1);
                SEG_OVERLONG: last = 1'b0;
                default: last = ($urandom_range(99) < 30);
            endcase
            send_pixel(random_channel(), random_channel(), random_channel(), last);
        end
    endtask

    // Reset values: ten-row bands in colour. Full white gives a white single row,
    // full black a black one.
    task automatic test_reset_defaults();
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        drain_rows();
    endtask

    // A segment that never marks its end is cut when it reaches the band height;
    // half-white averages give five white rows out of ten.
    task automatic test_overlong_segment();
        for (int i = 0; i < 10; i++) begin
            send_pixel((i % 2) ? 8'hff : 8'h00, (i % 2) ? 8'hff : 8'h00,
                       (i % 2) ? 8'hff : 8'h00, 1'b0);
        end
        drain_rows();
    endtask

    // The band shrinks below the pixels already held: the next pixel closes the
    // segment on its own. The unused register index is written on the way.
    task automatic test_band_change_mid_segment();
        configure(5'd4, 1'b0, 1'b1, 1'b0);
        send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
        send_pixel(8'd10, 8'd250, 8'd128, 1'b0);
        drain_rows();
        configure(5'd2, 1'b0, 1'b1, 1'b1);
        send_pixel(8'd77, 8'd33, 8'd199, 1'b0);
        drain_rows();
    endtask

    // Smallest band with the limit rule in gray, band heights below and above the
    // legal range, and a short segment that never reaches the forced black row.
    task automatic test_config_extremes();
        configure(5'd2, 1'b1, 1'b0, 1'b0);
        send_pixel(8'hff, 8'h12, 8'h34, 1'b0);
        send_pixel(8'h00, 8'hab, 8'hcd, 1'b1);
        drain_rows();
        configure(5'd0, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd254, 8'h00, 8'hff, 1'b1);
        send_pixel(8'd253, 8'hff, 8'h00, 1'b1);
        drain_rows();
        configure(5'd31, 1'b1, 1'b1, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        drain_rows();
    endtask

    // Random phases, each under its own configuration. Most segments are well formed
    // with random pixels; the rest run past the band or mark their end at random.
    task automatic test_random_segments();
        logic [CFG_BAND_W-1:0] band;
        int                    phase_start;
        int unsigned           pick;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: band = 5'd16;
                1: band = 5'd2;
                2: band = 5'd31;
                3: band = 5'd1;
                default: band = CFG_BAND_W'($urandom_range(2, MAX_BAND_DEFAULT));
            endcase
            configure(band, 1'($urandom), 1'($urandom), 1'b0);
            // One phase runs with neither side idling.
            steady_flow = (phase == 2);
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_PIXELS) begin
                pick = $urandom_range(99);
                if (pick < 70) send_segment(SEG_WELL_FORMED);
                else if (pick < 85) send_segment(SEG_OVERLONG);
                else send_segment(SEG_NOISE);
            end
            drain_rows();
            steady_flow = 1'b0;
        end
    endtask

    // The receiver stops for a long stretch while full segments keep coming, so
    // the block must hold back further pixel requests until rows drain again.
    task automatic test_backpressure();
        configure(5'd16, 1'b1, 1'b1, 1'b0);
        hold_off_asked++;
        for (int i = 0; i < 3; i++) send_segment(SEG_OVERLONG);
        drain_rows();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_overlong_segment();
        test_band_change_mid_segment();
        test_config_extremes();
        test_random_segments();
        test_backpressure();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
